// ===== hw/rtl/crc16cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16cfr_pkg: shared definitions for the command frame receiver
// frame constants, event codes, parser phases and the byte-wide crc16 update
// ----------------------------------------------------------------------------
package crc16cfr_pkg;

    // largest number of bytes kept for one frame before the overflow abort
    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    // frame delimiters and crc settings
    localparam logic [7:0]  HDR_BYTE    = 8'h3A;
    localparam logic [7:0]  CR_BYTE     = 8'h0D;
    localparam logic [7:0]  LF_BYTE     = 8'h0A;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [9:0]  TRAILER_LEN = 10'd4;
    // offset of the first data byte: header, length, function
    localparam logic [CNT_W-1:0] DATA_OFS = CNT_W'(3);

    // result event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_CRC     = 3'd3,
        EV_TAIL    = 3'd4,
        EV_OVER    = 3'd5
    } t_event;

    // parser phases, one-hot
    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_LEN    = 8'b0000_0010,
        PH_FUNC   = 8'b0000_0100,
        PH_DATA   = 8'b0000_1000,
        PH_CRC_HI = 8'b0001_0000,
        PH_CRC_LO = 8'b0010_0000,
        PH_CR     = 8'b0100_0000,
        PH_LF     = 8'b1000_0000
    } t_phase;

    // crc16/modbus update by one byte, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc16_command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_command_frame_receiver: serial command frame parser with crc16 check
// hunts for frame header, forwards data bytes and reports a frame verdict
// ----------------------------------------------------------------------------
// Usage
// The rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received
// serial byte per transfer. Every accepted byte gives exactly one result
// transfer on the res channel (o_res_valid / i_res_ready): event none, a
// tentative payload byte with its index, or a verdict for the frame (good,
// crc error, tail error, overflow). Function code and stored length are
// valid with the good event. Tentative payload is to be dropped by the
// consumer on any verdict other than good.
// An accepted byte is held in the input register, and its result is
// then registered in the result register. Throughput: one byte per
// cycle unless the res channel stalls, set by the byte-wide crc update
// and the phase logic between the input and result registers.
// Reset (synchronous, active low) empties both registers and puts the
// parser back to hunting the header. When the receiver stalls, the result
// register holds, the input register fills and then o_rx_ready drops.
// ----------------------------------------------------------------------------
module crc16_command_frame_receiver
    import crc16cfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_function_code,
    output logic [7:0] o_stored_length
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    t_phase           r_phase,        n_phase;
    logic [CNT_W-1:0] r_byte_count,   n_byte_count;
    logic [7:0]       r_declared_len, n_declared_len;
    logic [7:0]       r_held_func,    n_held_func;
    logic [15:0]      r_running_crc,  n_running_crc;
    logic [7:0]       r_crc_high,     n_crc_high;

    // result register
    logic   r_out_valid;
    t_event r_event,         n_event;
    logic [7:0] r_payload_byte,  n_payload_byte;
    logic [7:0] r_payload_index, n_payload_index;
    logic [7:0] r_function_code, n_function_code;
    logic [7:0] r_stored_length, n_stored_length;

    logic             advance;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] data_pos;
    logic [15:0]      crc_fed;
    logic             trailer_hit;
    logic             over_hit;

    // pipeline handshake
    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    // datapath helpers
    assign cnt_inc     = r_byte_count + CNT_W'(1);
    assign data_pos    = r_byte_count - DATA_OFS;
    assign crc_fed     = crc_feed(r_running_crc, r_in_byte);
    assign trailer_hit = ({2'b00, r_declared_len}) ==
                         (10'(cnt_inc) + TRAILER_LEN);
    assign over_hit    = r_byte_count >= CNT_W'(MAX_FRAME);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // frame parser
    always_comb begin
        n_phase         = r_phase;
        n_byte_count    = r_byte_count;
        n_declared_len  = r_declared_len;
        n_held_func     = r_held_func;
        n_running_crc   = r_running_crc;
        n_crc_high      = r_crc_high;
        n_event         = EV_NONE;
        n_payload_byte  = 8'h00;
        n_payload_index = 8'h00;
        n_function_code = 8'h00;
        n_stored_length = 8'h00;

        if (over_hit) begin
            n_phase        = PH_HUNT;
            n_byte_count   = '0;
            n_declared_len = 8'h00;
            n_held_func    = 8'h00;
            n_running_crc  = CRC_INIT;
            n_crc_high     = 8'h00;
            n_event        = EV_OVER;
        end else begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_in_byte == HDR_BYTE) begin
                        n_phase        = PH_LEN;
                        n_byte_count   = CNT_W'(1);
                        n_declared_len = 8'h00;
                        n_held_func    = 8'h00;
                        n_running_crc  = crc_feed(CRC_INIT, HDR_BYTE);
                        n_crc_high     = 8'h00;
                    end
                end
                PH_LEN: begin
                    n_declared_len = r_in_byte;
                    n_running_crc  = crc_fed;
                    n_byte_count   = cnt_inc;
                    n_phase        = PH_FUNC;
                end
                PH_FUNC: begin
                    n_held_func   = r_in_byte;
                    n_running_crc = crc_fed;
                    n_byte_count  = cnt_inc;
                    n_phase       = trailer_hit ? PH_CRC_HI : PH_DATA;
                end
                PH_DATA: begin
                    n_event         = EV_PAYLOAD;
                    n_payload_byte  = r_in_byte;
                    n_payload_index = data_pos[7:0];
                    n_running_crc   = crc_fed;
                    n_byte_count    = cnt_inc;
                    if (trailer_hit) begin
                        n_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    n_crc_high = r_in_byte;
                    n_phase    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    if ({r_crc_high, r_in_byte} == r_running_crc) begin
                        n_phase = PH_CR;
                    end else begin
                        n_phase        = PH_HUNT;
                        n_byte_count   = '0;
                        n_declared_len = 8'h00;
                        n_held_func    = 8'h00;
                        n_running_crc  = CRC_INIT;
                        n_crc_high     = 8'h00;
                        n_event        = EV_CRC;
                    end
                end
                PH_CR: begin
                    if (r_in_byte == CR_BYTE) begin
                        n_byte_count = cnt_inc;
                        n_phase      = PH_LF;
                    end else begin
                        n_phase        = PH_HUNT;
                        n_byte_count   = '0;
                        n_declared_len = 8'h00;
                        n_held_func    = 8'h00;
                        n_running_crc  = CRC_INIT;
                        n_crc_high     = 8'h00;
                        n_event        = EV_TAIL;
                    end
                end
                PH_LF: begin
                    if (r_in_byte == LF_BYTE) begin
                        n_event         = EV_GOOD;
                        n_function_code = r_held_func;
                        n_stored_length = cnt_inc[7:0];
                    end else begin
                        n_event = EV_TAIL;
                    end
                    n_phase        = PH_HUNT;
                    n_byte_count   = '0;
                    n_declared_len = 8'h00;
                    n_held_func    = 8'h00;
                    n_running_crc  = CRC_INIT;
                    n_crc_high     = 8'h00;
                end
                default: begin
                    n_phase        = PH_HUNT;
                    n_byte_count   = '0;
                    n_declared_len = 8'h00;
                    n_held_func    = 8'h00;
                    n_running_crc  = CRC_INIT;
                    n_crc_high     = 8'h00;
                end
            endcase
        end
    end

    // parser state, updated when the byte moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_byte_count   <= '0;
            r_declared_len <= 8'h00;
            r_held_func    <= 8'h00;
            r_running_crc  <= CRC_INIT;
            r_crc_high     <= 8'h00;
        end else if (advance) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_declared_len <= n_declared_len;
            r_held_func    <= n_held_func;
            r_running_crc  <= n_running_crc;
            r_crc_high     <= n_crc_high;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_event         <= n_event;
            r_payload_byte  <= n_payload_byte;
            r_payload_index <= n_payload_index;
            r_function_code <= n_function_code;
            r_stored_length <= n_stored_length;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_event_res     = r_event;
    assign o_payload_byte  = r_payload_byte;
    assign o_payload_index = r_payload_index;
    assign o_function_code = r_function_code;
    assign o_stored_length = r_stored_length;

    // checks

    // kept byte count never passes the overflow limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_FRAME))
        else $error("byte count beyond frame limit");

    // a stalled result freezes the parser
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=>
            ($stable(r_phase) && $stable(r_running_crc) && $stable(r_byte_count)))
        else $error("parser state moved while result stalled");

    // payload fields are zero unless the event is a payload byte
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != EV_PAYLOAD) |->
            (r_payload_byte == 8'h00 && r_payload_index == 8'h00))
        else $error("payload fields set without payload event");

    // a good frame holds at least header, length, function and tail
    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == EV_GOOD) |-> (r_stored_length >= 8'd5))
        else $error("good frame with short stored length");

    // the parser is hunting whenever the kept count is zero
    a_hunt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count == '0) |-> (r_phase == PH_HUNT))
        else $error("frame phase active with empty byte count");

endmodule

// ===== tb/crc16_command_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// crc16_command_frame_receiver_tb: self-checking bench for the frame receiver
// feeds serial bytes as directed and random frames with crc, tail and
// overflow faults, predicts the result of every byte transfer and checks it
// field by field against the result channel under random stalls
// ----------------------------------------------------------------------------
module crc16_command_frame_receiver_tb;
    import crc16cfr_pkg::*;

    // one expected or observed result
    typedef struct {
        t_event     ev;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] func;
        logic [7:0] length;
    } t_res_rec;

    // ways to spoil a frame
    typedef enum {FLT_NONE, FLT_CRC, FLT_CR, FLT_LF} t_fault;

    // frame parser model plus queue of expected results
    class deframer_scoreboard;
        t_res_rec         expected_q[$];
        int               mismatches;
        t_phase           phase;
        logic [CNT_W-1:0] kept_count;
        logic [7:0]       declared_len;
        logic [7:0]       func_code;
        logic [7:0]       crc_hi_rx;
        logic [15:0]      crc_acc;

        function new();
            mismatches = 0;
            rearm();
        endfunction

        // crc16/modbus, one data bit per step
        static function logic [15:0] crc16_modbus(logic [15:0] crc, logic [7:0] b);
            logic mix;
            for (int i = 0; i < 8; i++) begin
                mix = crc[0] ^ b[i];
                crc = crc >> 1;
                if (mix) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            return crc;
        endfunction

        function void rearm();
            phase        = PH_HUNT;
            kept_count   = '0;
            declared_len = '0;
            func_code    = '0;
            crc_acc      = CRC_INIT;
            crc_hi_rx    = '0;
        endfunction

        function void take_byte(logic [7:0] b, bit in_crc);
            if (in_crc) begin
                crc_acc = crc16_modbus(crc_acc, b);
            end
            kept_count = kept_count + 1'b1;
        endfunction

        function bit at_trailer();
            return int'(declared_len) - int'(kept_count) == int'(TRAILER_LEN);
        endfunction

        // advance the parser by one accepted byte and queue its result
        function void note_byte(logic [7:0] b);
            t_res_rec r;
            r = '{EV_NONE, 8'h00, 8'h00, 8'h00, 8'h00};
            if (int'(kept_count) >= MAX_FRAME) begin
                rearm();
                r.ev = EV_OVER;
            end else begin
                case (phase)
                    PH_HUNT: begin
                        if (b == HDR_BYTE) begin
                            rearm();
                            take_byte(b, 1'b1);
                            phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        declared_len = b;
                        take_byte(b, 1'b1);
                        phase = PH_FUNC;
                    end
                    PH_FUNC: begin
                        func_code = b;
                        take_byte(b, 1'b1);
                        phase = at_trailer() ? PH_CRC_HI : PH_DATA;
                    end
                    PH_DATA: begin
                        r.ev    = EV_PAYLOAD;
                        r.data  = b;
                        r.index = 8'(kept_count - DATA_OFS);
                        take_byte(b, 1'b1);
                        if (at_trailer()) begin
                            phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        crc_hi_rx = b;
                        phase     = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        if ({crc_hi_rx, b} == crc_acc) begin
                            phase = PH_CR;
                        end else begin
                            rearm();
                            r.ev = EV_CRC;
                        end
                    end
                    PH_CR: begin
                        if (b == CR_BYTE) begin
                            take_byte(b, 1'b0);
                            phase = PH_LF;
                        end else begin
                            rearm();
                            r.ev = EV_TAIL;
                        end
                    end
                    default: begin
                        if (b == LF_BYTE) begin
                            take_byte(b, 1'b0);
                            r.ev     = EV_GOOD;
                            r.func   = func_code;
                            r.length = kept_count[7:0];
                        end else begin
                            r.ev = EV_TAIL;
                        end
                        rearm();
                    end
                endcase
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 20) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        // compare one result transfer with the oldest expectation
        task check_event(logic [2:0] ev, logic [7:0] data, logic [7:0] index,
                         logic [7:0] func, logic [7:0] length);
            t_res_rec e;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected, event %0d", ev));
                return;
            end
            e = expected_q.pop_front();
            if (ev !== e.ev) begin
                report($sformatf("event %0d, expected %0d", ev, e.ev));
            end
            if (data !== e.data) begin
                report($sformatf("payload byte %h, expected %h", data, e.data));
            end
            if (index !== e.index) begin
                report($sformatf("payload index %0d, expected %0d", index, e.index));
            end
            if (func !== e.func) begin
                report($sformatf("function code %h, expected %h", func, e.func));
            end
            if (length !== e.length) begin
                report($sformatf("stored length %0d, expected %0d", length, e.length));
            end
        endtask
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_ready = 1'b0;
    logic       rx_ready;
    logic       res_valid;
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] function_code;
    logic [7:0] stored_length;

    deframer_scoreboard board;
    int sent_items = 0;
    int tx_left    = 0;
    bit tx_calm    = 1'b0;
    int ack_left   = 0;
    bit ack_calm   = 1'b0;

    crc16_command_frame_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_event_res     (event_res),
        .o_payload_byte  (payload_byte),
        .o_payload_index (payload_index),
        .o_function_code (function_code),
        .o_stored_length (stored_length)
    );

    always #5 i_clk = ~i_clk;

    // idle cycles before the next transfer, with calm stretches of no idling
    function automatic int draw_gap(ref int left, ref bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(8, 40);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // one byte transfer on the rx channel
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_left, tx_calm);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!rx_ready);
        board.note_byte(b);
        sent_items++;
    endtask

    // build a frame and send it, cut short right after a spoiled byte;
    // a length below seven runs on to the overflow byte, spill
    task automatic send_frame(input logic [7:0] len, input logic [7:0] func,
                              input t_fault fault, input int fill,
                              input logic [7:0] spill);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        logic [7:0]  bad;
        int          n_data;
        int          n_send;
        frame_q = {HDR_BYTE, len, func};
        n_data  = (len < 8'd7) ? MAX_FRAME - 3 : int'(len) - 7;
        for (int i = 0; i < n_data; i++) begin
            frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        end
        if (len < 8'd7) begin
            frame_q.push_back(spill);
            n_send = frame_q.size();
        end else begin
            crc = CRC_INIT;
            foreach (frame_q[i]) begin
                crc = deframer_scoreboard::crc16_modbus(crc, frame_q[i]);
            end
            if (fault == FLT_CRC) begin
                crc = crc ^ (16'd1 << $urandom_range(0, 15));
            end
            frame_q.push_back(crc[15:8]);
            frame_q.push_back(crc[7:0]);
            do bad = 8'($urandom); while (bad == CR_BYTE);
            frame_q.push_back(fault == FLT_CR ? bad : CR_BYTE);
            do bad = 8'($urandom); while (bad == LF_BYTE);
            frame_q.push_back(fault == FLT_LF ? bad : LF_BYTE);
            n_send = frame_q.size() - (fault == FLT_CRC ? 2 : fault == FLT_CR ? 1 : 0);
        end
        for (int i = 0; i < n_send; i++) begin
            send_byte(frame_q[i]);
        end
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // result receiver with random stalls
    initial begin
        int stall;
        forever begin
            stall = draw_gap(ack_left, ack_calm);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!(res_valid && i_rst_n));
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_valid && res_ready) begin
            board.check_event(event_res, payload_byte, payload_index,
                              function_code, stored_length);
        end
    end

    // stimulus
    initial begin
        int     pick;
        logic [7:0] len;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no data area, extreme data and function codes, crc and tail faults
        send_frame(8'd7, 8'h00, FLT_NONE, -1, 8'h00);
        send_frame(8'd8, 8'hFF, FLT_NONE, 8'hFF, 8'h00);
        send_frame(8'd7, 8'h5A, FLT_CRC, -1, 8'h00);
        send_frame(8'd7, 8'hA5, FLT_CR, -1, 8'h00);
        drain();

        // length below seven: data until the overflow abort
        send_frame(8'd0, 8'($urandom), FLT_NONE, -1, HDR_BYTE);
        send_frame(8'd6, 8'($urandom), FLT_NONE, -1, 8'($urandom));
        drain();

        // random mix of frames, faults and line noise up to the item budget
        while (sent_items < 600) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(17, 255))
                                                : 8'($urandom_range(7, 16));
            if (pick < 10) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (pick < 70) begin
                send_frame(len, 8'($urandom), FLT_NONE, -1, 8'h00);
            end else if (pick < 80) begin
                send_frame(len, 8'($urandom), FLT_CRC, -1, 8'h00);
            end else if (pick < 88) begin
                send_frame(len, 8'($urandom), FLT_CR, -1, 8'h00);
            end else if (pick < 96) begin
                send_frame(len, 8'($urandom), FLT_LF, -1, 8'h00);
            end else begin
                send_frame(8'($urandom_range(7, 10)), 8'($urandom),
                           t_fault'($urandom_range(1, 3)), -1, 8'h00);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/crc16cfr_pkg.sv
hw/rtl/crc16_command_frame_receiver.sv
tb/crc16_command_frame_receiver_tb.sv
